/* design/mfde_pkg.sv */
// Shared types, codes and defaults for the monochrome framebuffer draw engine.
`default_nettype none

package mfde_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  // Command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_LINE  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Work kinds handed to the pixel walker
  typedef enum logic [2:0] {
    WK_NONE,
    WK_CLEAR,
    WK_LINE,
    WK_RECT,
    WK_READ
  } walk_kind_t;

  // Pixel walker states
  typedef enum logic [2:0] {
    WS_IDLE,
    WS_CLEAR,
    WS_LINE,
    WS_RECT,
    WS_READ
  } walk_state_t;

  // Top level sequencer states
  typedef enum logic [1:0] {
    TS_INIT,
    TS_IDLE,
    TS_RUN,
    TS_DONE
  } top_state_t;

  // One command item
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] xa;
    logic [7:0] ya;
    logic [7:0] xb;
    logic [7:0] yb;
    logic       color;
  } cmd_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read;
  } res_item_t;

  // Start request from the sequencer to the walker
  typedef struct packed {
    logic       start;
    walk_kind_t kind;
    logic [7:0] xa;
    logic [7:0] ya;
    logic [7:0] xb;
    logic [7:0] yb;
    logic       color;
  } walk_req_t;

  // One on-screen pixel access from the walker to the read-modify-write unit
  typedef struct packed {
    logic       valid;
    logic       wr;        // 0: read only
    logic [7:0] x;
    logic [7:0] y;
    logic       mask_all;  // whole byte, used by clear
    logic       color;
  } pix_t;

  // Read response from the read-modify-write unit
  typedef struct packed {
    logic       rd_valid;
    logic [7:0] data;
  } rmw_resp_t;

endpackage

`default_nettype wire

/* design/mfde_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none

module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/mfde_walk.sv */
// Pixel walker: turns a command into a stream of on-screen pixel accesses, one per cycle.
`default_nettype none

module mfde_walk #(
  parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfde_pkg::walk_req_t req,
  output logic                   busy,
  output mfde_pkg::pix_t         pix
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);
  localparam logic [7:0] CLR_LAST_X = 8'(SCREEN_WIDTH - 1);
  localparam logic [7:0] CLR_LAST_Y = 8'((PAGES - 1) * 8);

  mfde_pkg::walk_state_t state, state_next;

  logic [7:0]        cur_x, cur_x_next;
  logic [7:0]        cur_y, cur_y_next;
  logic [7:0]        end_x, end_x_next;     // line end, or last rectangle column
  logic [7:0]        end_y, end_y_next;     // line end, or last rectangle row
  logic [7:0]        first_y, first_y_next;
  logic [7:0]        adx, adx_next;
  logic [7:0]        ady, ady_next;
  logic              sx_neg, sx_neg_next;
  logic              sy_neg, sy_neg_next;
  logic signed [10:0] err, err_next;
  logic              color, color_next;

  // Clip test on the current point
  logic on_screen;
  assign on_screen = ({1'b0, cur_x} < W9) && ({1'b0, cur_y} < H9);

  // Bresenham step decisions
  logic signed [11:0] e2;
  logic signed [11:0] adx_s;
  logic signed [11:0] ady_s;
  logic               step_x;
  logic               step_y;
  logic signed [10:0] err_step;
  assign e2     = {err, 1'b0};
  assign adx_s  = $signed({4'b0000, adx});
  assign ady_s  = $signed({4'b0000, ady});
  assign step_x = e2 > -ady_s;
  assign step_y = e2 < adx_s;
  assign err_step = err
                  - (step_x ? $signed({3'b000, ady}) : 11'sd0)
                  + (step_y ? $signed({3'b000, adx}) : 11'sd0);

  // Line setup from the request
  logic [7:0]         adx_init;
  logic [7:0]         ady_init;
  logic signed [10:0] err_init;
  assign adx_init = (req.xb >= req.xa) ? (req.xb - req.xa) : (req.xa - req.xb);
  assign ady_init = (req.yb >= req.ya) ? (req.yb - req.ya) : (req.ya - req.yb);
  assign err_init = $signed({3'b000, adx_init}) - $signed({3'b000, ady_init});

  // Rectangle setup: wrapped end, clipped to the screen
  logic [7:0] rx_end;
  logic [7:0] ry_end;
  logic [8:0] rx_clip;
  logic [8:0] ry_clip;
  logic [8:0] rx_last;
  logic [8:0] ry_last;
  logic       rect_ok;
  assign rx_end  = req.xa + req.xb;
  assign ry_end  = req.ya + req.yb;
  assign rx_clip = ({1'b0, rx_end} < W9) ? {1'b0, rx_end} : W9;
  assign ry_clip = ({1'b0, ry_end} < H9) ? {1'b0, ry_end} : H9;
  assign rx_last = rx_clip - 9'd1;
  assign ry_last = ry_clip - 9'd1;
  assign rect_ok = (rx_clip > {1'b0, req.xa}) && (ry_clip > {1'b0, req.ya});

  assign busy = (state != mfde_pkg::WS_IDLE);

  // Next state, walk registers and pixel output
  always_comb begin
    state_next   = state;
    cur_x_next   = cur_x;
    cur_y_next   = cur_y;
    end_x_next   = end_x;
    end_y_next   = end_y;
    first_y_next = first_y;
    adx_next     = adx;
    ady_next     = ady;
    sx_neg_next  = sx_neg;
    sy_neg_next  = sy_neg;
    err_next     = err;
    color_next   = color;
    pix          = '0;
    pix.x        = cur_x;
    pix.y        = cur_y;
    pix.color    = color;

    case (state)
      mfde_pkg::WS_IDLE: begin
        if (req.start) begin
          color_next = req.color;
          case (req.kind)
            mfde_pkg::WK_CLEAR: begin
              cur_x_next = '0;
              cur_y_next = '0;
              state_next = mfde_pkg::WS_CLEAR;
            end
            mfde_pkg::WK_LINE: begin
              cur_x_next  = req.xa;
              cur_y_next  = req.ya;
              end_x_next  = req.xb;
              end_y_next  = req.yb;
              adx_next    = adx_init;
              ady_next    = ady_init;
              sx_neg_next = req.xb < req.xa;
              sy_neg_next = req.yb < req.ya;
              err_next    = err_init;
              state_next  = mfde_pkg::WS_LINE;
            end
            mfde_pkg::WK_RECT: begin
              if (rect_ok) begin
                cur_x_next   = req.xa;
                cur_y_next   = req.ya;
                first_y_next = req.ya;
                end_x_next   = rx_last[7:0];
                end_y_next   = ry_last[7:0];
                state_next   = mfde_pkg::WS_RECT;
              end
            end
            mfde_pkg::WK_READ: begin
              cur_x_next = req.xa;
              cur_y_next = req.ya;
              state_next = mfde_pkg::WS_READ;
            end
            default: begin
            end
          endcase
        end
      end

      // Whole-byte zero writes, column by column within each page
      mfde_pkg::WS_CLEAR: begin
        pix.valid    = 1'b1;
        pix.wr       = 1'b1;
        pix.mask_all = 1'b1;
        pix.color    = 1'b0;
        if (cur_x == CLR_LAST_X) begin
          cur_x_next = '0;
          if (cur_y == CLR_LAST_Y) begin
            state_next = mfde_pkg::WS_IDLE;
          end else begin
            cur_y_next = cur_y + 8'd8;
          end
        end else begin
          cur_x_next = cur_x + 8'd1;
        end
      end

      // One point per cycle, clipped, until the end point is plotted
      mfde_pkg::WS_LINE: begin
        pix.valid = on_screen;
        pix.wr    = 1'b1;
        if (cur_x == end_x && cur_y == end_y) begin
          state_next = mfde_pkg::WS_IDLE;
        end else begin
          err_next = err_step;
          if (step_x) begin
            cur_x_next = cur_x + (sx_neg ? 8'hFF : 8'h01);
          end
          if (step_y) begin
            cur_y_next = cur_y + (sy_neg ? 8'hFF : 8'h01);
          end
        end
      end

      // Column-major sweep of the clipped rectangle
      mfde_pkg::WS_RECT: begin
        pix.valid = on_screen;
        pix.wr    = 1'b1;
        if (cur_y == end_y) begin
          cur_y_next = first_y;
          if (cur_x == end_x) begin
            state_next = mfde_pkg::WS_IDLE;
          end else begin
            cur_x_next = cur_x + 8'd1;
          end
        end else begin
          cur_y_next = cur_y + 8'd1;
        end
      end

      // Single read access; offscreen reads issue nothing
      mfde_pkg::WS_READ: begin
        pix.valid  = on_screen;
        pix.wr     = 1'b0;
        state_next = mfde_pkg::WS_IDLE;
      end

      default: begin
        state_next = mfde_pkg::WS_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the power-up clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfde_pkg::WS_CLEAR;
      cur_x <= '0;
      cur_y <= '0;
    end else begin
      state <= state_next;
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
    end
  end

  // Walk parameters
  always_ff @(posedge clk) begin
    end_x   <= end_x_next;
    end_y   <= end_y_next;
    first_y <= first_y_next;
    adx     <= adx_next;
    ady     <= ady_next;
    sx_neg  <= sx_neg_next;
    sy_neg  <= sy_neg_next;
    err     <= err_next;
    color   <= color_next;
  end

endmodule

`default_nettype wire

/* design/mfde_rmw.sv */
// Read-modify-write unit around the frame store, with one-deep write forwarding.
`default_nettype none

module mfde_rmw #(
  parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mfde_pkg::pix_t  pix,
  output mfde_pkg::rmw_resp_t  resp
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);

  // Byte address and bit mask of the incoming pixel
  logic [31:0]   addr_wide;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  assign addr_wide = 32'(pix.y[7:3]) * 32'(SCREEN_WIDTH) + 32'(pix.x);
  assign pix_addr  = addr_wide[AW-1:0];
  assign pix_mask  = pix.mask_all ? 8'hFF : (8'b1 << pix.y[2:0]);

  // Access waiting for its read data
  logic          s1_valid;
  logic          s1_wr;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_mask;
  logic          s1_color;

  // Write done in the previous cycle, not yet seen by the read port
  logic          last_valid;
  logic [AW-1:0] last_addr;
  logic [7:0]    last_data;

  logic [7:0] ram_rdata;
  logic [7:0] cur_byte;
  logic [7:0] new_byte;
  logic       we;

  assign cur_byte = (last_valid && last_addr == s1_addr) ? last_data : ram_rdata;
  assign new_byte = s1_color ? (cur_byte | s1_mask) : (cur_byte & ~s1_mask);
  assign we       = s1_valid && s1_wr;

  assign resp.rd_valid = s1_valid && !s1_wr;
  assign resp.data     = cur_byte;

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (new_byte),
    .re    (pix.valid),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_wr      <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      s1_valid   <= pix.valid;
      s1_wr      <= pix.wr;
      last_valid <= we;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_addr   <= pix_addr;
    s1_mask   <= pix_mask;
    s1_color  <= pix.color;
    last_addr <= s1_addr;
    last_data <= new_byte;
  end

endmodule

`default_nettype wire

/* design/mono_framebuffer_draw_engine_core.sv */
// Top level: command sequencer, pixel walker, frame store RMW unit and result register.
// Each command walks n pixels, n depending on the kind (pixel, read: n = 1;
//   line: max(|dx|,|dy|) + 1; rectangle: on-screen area; clear: width * pages).
// Throughput: no new command is taken until the last result is loaded for output; the
//   walker emits one pixel a cycle and the frame store RAM does one read-modify-write a cycle.
// Reset: a clearing pass writes zero to all width * pages bytes before the first
//   command is taken.
`default_nettype none

module mono_framebuffer_draw_engine_core #(
  parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire mfde_pkg::cmd_item_t cmd_item,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output mfde_pkg::res_item_t      res_item
);

  mfde_pkg::top_state_t state, state_next;
  mfde_pkg::walk_req_t  walk_req;
  mfde_pkg::pix_t       pix;
  mfde_pkg::rmw_resp_t  resp;
  logic                 walk_busy;
  logic                 accept;
  logic                 load;

  // Result being built for the current command
  logic [7:0] res_data;
  logic       res_is_read;

  assign cmd_stall = (state != mfde_pkg::TS_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  // Sequencer next state and walker request
  always_comb begin
    state_next     = state;
    load           = 1'b0;
    walk_req       = '0;
    walk_req.kind  = mfde_pkg::WK_NONE;
    walk_req.xa    = cmd_item.xa;
    walk_req.ya    = cmd_item.ya;
    walk_req.xb    = cmd_item.xb;
    walk_req.yb    = cmd_item.yb;
    walk_req.color = cmd_item.color;

    case (state)
      mfde_pkg::TS_INIT: begin
        if (!walk_busy) begin
          state_next = mfde_pkg::TS_IDLE;
        end
      end
      mfde_pkg::TS_IDLE: begin
        if (accept) begin
          walk_req.start = 1'b1;
          state_next     = mfde_pkg::TS_RUN;
          case (mfde_pkg::cmd_t'(cmd_item.cmd))
            mfde_pkg::CMD_CLEAR: walk_req.kind = mfde_pkg::WK_CLEAR;
            mfde_pkg::CMD_PIXEL: begin
              // a single pixel is a line of one point
              walk_req.kind = mfde_pkg::WK_LINE;
              walk_req.xb   = cmd_item.xa;
              walk_req.yb   = cmd_item.ya;
            end
            mfde_pkg::CMD_RECT:  walk_req.kind = mfde_pkg::WK_RECT;
            mfde_pkg::CMD_LINE:  walk_req.kind = mfde_pkg::WK_LINE;
            mfde_pkg::CMD_READ:  walk_req.kind = mfde_pkg::WK_READ;
            default:             walk_req.kind = mfde_pkg::WK_NONE;
          endcase
        end
      end
      mfde_pkg::TS_RUN: begin
        if (!walk_busy) begin
          state_next = mfde_pkg::TS_DONE;
        end
      end
      mfde_pkg::TS_DONE: begin
        if (!res_valid || !res_stall) begin
          load       = 1'b1;
          state_next = mfde_pkg::TS_IDLE;
        end
      end
      default: begin
        state_next = mfde_pkg::TS_INIT;
      end
    endcase
  end

  mfde_walk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .req  (walk_req),
    .busy (walk_busy),
    .pix  (pix)
  );

  mfde_rmw #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_rmw (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .resp (resp)
  );

  // Control: sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfde_pkg::TS_INIT;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_stall == 1'b0) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: zero unless a read response arrives
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data    <= '0;
      res_is_read <= (cmd_item.cmd == mfde_pkg::CMD_READ);
    end else if (resp.rd_valid) begin
      res_data <= resp.data;
    end
    if (load) begin
      res_item.read_data <= res_data;
      res_item.is_read   <= res_is_read;
    end
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the monochrome framebuffer draw engine core.
`timescale 1ns / 1ps

module tb;

  localparam int SCR_W = mfde_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H = mfde_pkg::SCREEN_HEIGHT_DEF;
  localparam int FB_BYTES = SCR_W * ((SCR_H + 7) / 8);
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  // full-screen rectangle plus stalls, taken several times over
  localparam int QUIET_LIMIT = 60000;
  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // Shadow framebuffer and the queue of answers still owed by the block
  class draw_scoreboard;
    logic [7:0]          shadow_fb [FB_BYTES];
    mfde_pkg::res_item_t pending [$];
    int                  errors;

    function new();
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    endfunction

    // one pixel; offscreen ones are dropped
    function void plot(int x, int y, bit c);
      if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
      shadow_fb[(y / 8) * SCR_W + x][y % 8] = c;
    endfunction

    // end column and row wrap at 256, so the span may be empty
    function void fill_rect(int x, int y, int w, int h, bit c);
      int xe, ye, i, j;
      xe = (x + w) & 255;
      ye = (y + h) & 255;
      for (i = x; i < xe; i++)
        for (j = y; j < ye; j++)
          plot(i, j, c);
    endfunction

    // Bresenham walk, both ends inclusive
    function void draw_line(int x0, int y0, int x1, int y1, bit c);
      int dx, dy, adx, ady, sx, sy, err, e2, cx, cy, steps;
      dx = x1 - x0;
      dy = y1 - y0;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      sx = (dx >= 0) ? 1 : -1;
      sy = (dy >= 0) ? 1 : -1;
      err = adx - ady;
      cx = x0;
      cy = y0;
      for (steps = 0; steps < 600; steps++) begin
        plot(cx & 255, cy & 255, c);
        if (cx == x1 && cy == y1) break;
        e2 = 2 * err;
        if (e2 > -ady) begin
          err -= ady;
          cx += sx;
        end
        if (e2 < adx) begin
          err += adx;
          cy += sy;
        end
      end
    endfunction

    // apply an accepted command and queue the answer it owes
    function void note_command(mfde_pkg::cmd_item_t it);
      mfde_pkg::res_item_t r;
      r = '0;
      case (it.cmd)
        mfde_pkg::CMD_CLEAR: wipe();
        mfde_pkg::CMD_PIXEL: plot(it.xa, it.ya, it.color);
        mfde_pkg::CMD_RECT:  fill_rect(it.xa, it.ya, it.xb, it.yb, it.color);
        mfde_pkg::CMD_LINE:  draw_line(it.xa, it.ya, it.xb, it.yb, it.color);
        mfde_pkg::CMD_READ: begin
          r.is_read = 1'b1;
          if (it.xa < SCR_W && it.ya < SCR_H)
            r.read_data = shadow_fb[(it.ya / 8) * SCR_W + it.xa];
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_answer(mfde_pkg::res_item_t got);
      mfde_pkg::res_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: read_data %02h is_read %0b", got.read_data, got.is_read);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %02h, got %02h", want.read_data, got.read_data);
        errors++;
      end
      if (got.is_read !== want.is_read) begin
        $error("is_read: expected %0b, got %0b", want.is_read, got.is_read);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  mfde_pkg::cmd_item_t cmd_item;
  logic                res_valid;
  logic                res_stall;
  mfde_pkg::res_item_t res_item;

  logic      calm;       // no idling on either side
  logic      hold_off;   // receiver asked to hold a long stall
  logic      hold_done;  // the long stall has run
  int        quiet_cycles;
  draw_scoreboard sb;

  mono_framebuffer_draw_engine_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic mfde_pkg::cmd_item_t mk(logic [2:0] c, int xa, int ya, int xb, int yb,
                                             bit color);
    mfde_pkg::cmd_item_t it;
    it.cmd = c;
    it.xa = 8'(xa);
    it.ya = 8'(ya);
    it.xb = 8'(xb);
    it.yb = 8'(yb);
    it.color = color;
    return it;
  endfunction

  // mostly on screen, sometimes anywhere in the 8-bit range
  function automatic logic [7:0] pick_x();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SCR_W - 1))
                                        : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_y();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SCR_H - 1))
                                        : 8'($urandom_range(0, 255));
  endfunction

  // rectangle sides: mostly small, a few up to full range
  function automatic logic [7:0] pick_span();
    return ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 12));
  endfunction

  // offer one item until accepted, then maybe idle a few cycles
  task automatic send_cmd(input mfde_pkg::cmd_item_t it);
    cmd_valid <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(it);
    if (!calm && !(hold_off && !hold_done)) begin
      while ($urandom_range(0, 99) < 25) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Result side: random stall, one long hold-off on request
  initial begin
    res_stall <= 1'b0;
    hold_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      res_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  // Compare every accepted result
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_answer(res_item);
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    mfde_pkg::cmd_item_t it;
    int n;
    int pick;
    sb = new();
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_item <= '0;
    calm <= 1'b0;
    hold_off <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, corner pixels, clipping, clear, rectangles, lines, no-ops
    send_cmd(mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_PIXEL, SCR_W, 0, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_PIXEL, 0, SCR_H, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_PIXEL, 255, 255, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_READ, SCR_W - 1, SCR_H - 1, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_READ, SCR_W, 0, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_READ, 0, 255, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_READ, SCR_W - 1, SCR_H - 1, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_RECT, 0, 0, 8, 8, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_RECT, 250, 0, 10, 10, 1'b1));    // end wraps below start
    send_cmd(mk(mfde_pkg::CMD_RECT, 120, 56, 20, 20, 1'b1));   // clipped at the corner
    send_cmd(mk(mfde_pkg::CMD_RECT, 2, 2, 0, 5, 1'b1));        // zero width
    send_cmd(mk(mfde_pkg::CMD_RECT, 2, 0, 3, 3, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_READ, 3, 0, 0, 0, 1'b0));
    send_cmd(mk(mfde_pkg::CMD_LINE, 0, 0, SCR_W - 1, SCR_H - 1, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_LINE, SCR_W - 1, 0, 0, SCR_H - 1, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_LINE, 5, 0, 7, SCR_H - 1, 1'b0)); // steep, clearing
    send_cmd(mk(mfde_pkg::CMD_LINE, 200, 200, 100, 30, 1'b1)); // mostly off screen
    send_cmd(mk(mfde_pkg::CMD_LINE, 10, 10, 10, 10, 1'b1));    // single point
    send_cmd(mk(CMD_UNUSED_HI, 255, 255, 255, 255, 1'b1));
    send_cmd(mk(mfde_pkg::CMD_READ, 64, 32, 0, 0, 1'b0));

    // random mix, weighted toward drawing and reading back
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_off <= 1'b1;
      calm <= (n >= 900 && n < 1150);
      pick = $urandom_range(0, 99);
      it.color = ($urandom_range(0, 99) < 70);
      it.xa = pick_x();
      it.ya = pick_y();
      it.xb = pick_x();
      it.yb = pick_y();
      if (pick < 28) begin
        it.cmd = mfde_pkg::CMD_PIXEL;
      end else if (pick < 58) begin
        it.cmd = mfde_pkg::CMD_READ;
      end else if (pick < 73) begin
        it.cmd = mfde_pkg::CMD_LINE;
      end else if (pick < 95) begin
        it.cmd = mfde_pkg::CMD_RECT;
        it.xb = pick_span();
        it.yb = pick_span();
      end else if (pick < 97) begin
        it.cmd = mfde_pkg::CMD_CLEAR;
      end else begin
        it.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      send_cmd(it);
    end
    cmd_valid <= 1'b0;

    // let every owed answer arrive, then watch for strays
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
